@@ hw/rtl/deque_with_search_top_macros.svh @@
// ----------------------------------------------------------------------------
// Deque with search: assertion macros
// Shared concurrent assertion helpers for the deque RTL.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_SEARCH_TOP_MACROS_SVH
`define DEQUE_WITH_SEARCH_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define DQS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed");
`define DQS_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define DQS_ASSERT_IMPLY(label, clk, rst_n, a, b)
`define DQS_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

@@ hw/rtl/dqs_pkg.sv @@
// ----------------------------------------------------------------------------
// Deque with search: package
// Request/result types, operation and status codes, cell control.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dqs_pkg;

	typedef enum logic [2:0] {
		FUNC_PUSH_FRONT = 3'd0,
		FUNC_PUSH_BACK  = 3'd1,
		FUNC_POP_FRONT  = 3'd2,
		FUNC_POP_BACK   = 3'd3,
		FUNC_SEARCH     = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_MISS  = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_SWEEP
	} state_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_PUSH_FRONT,
		CELL_PUSH_BACK,
		CELL_POP_FRONT,
		CELL_ROTATE
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     at_count;
		logic     at_last;
	} cell_ctrl_t;

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] item_value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] popped_value;
		logic [3:0]         match_position;
		logic [4:0]         entry_count;
	} rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/dqs_cell.sv @@
// ----------------------------------------------------------------------------
// Deque with search: storage cell
// One entry of the deque; takes its value from a neighbor or the load bus.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dqs_cell (
	input  wire logic               clk,
	input  wire dqs_pkg::cell_ctrl_t ctrl,
	input  wire logic signed [31:0] prev_data,
	input  wire logic signed [31:0] next_data,
	input  wire logic signed [31:0] load_data,
	output logic signed [31:0]      data
);

	logic signed [31:0] data_q;
	logic signed [31:0] data_d;

	always_comb begin
		data_d = data_q;
		case (ctrl.op)
			dqs_pkg::CELL_PUSH_FRONT: data_d = prev_data;
			dqs_pkg::CELL_PUSH_BACK: begin
				if (ctrl.at_count) data_d = load_data;
			end
			dqs_pkg::CELL_POP_FRONT: data_d = next_data;
			dqs_pkg::CELL_ROTATE: data_d = ctrl.at_last ? load_data : next_data;
			default: data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

@@ hw/rtl/deque_with_search_top.sv @@
// ----------------------------------------------------------------------------
// Deque with search: top level
// Bounded double-ended queue held in a row of cells, with value search.
//
//   channel   signals                 handshake
//   request   start, busy, request    taken when start && !busy
//   result    done, result            valid for one cycle, no backpressure
//
// Push front/back, pop front and unused codes: the result is registered and
// appears in the cycle after the request; a new request may follow at once.
// Pop back and search: the row rotates once around the held entries, one
// step per cycle; busy stays high through the rotation and the result is
// registered after its last step. Empty queue: no rotation, result as above.
// Reset clears the count and the controller; entry contents are not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "deque_with_search_top_macros.svh"

module deque_with_search_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire dqs_pkg::req_t request,
	output logic               done,
	output dqs_pkg::rsp_t      result
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = $clog2(QUEUE_DEPTH);

	dqs_pkg::state_t state_q, state_d;
	logic [CW-1:0]      count_q, count_d;
	logic [IW-1:0]      step_q, step_d;
	logic               search_q, search_d;
	logic               found_q, found_d;
	logic [IW-1:0]      pos_q, pos_d;
	logic signed [31:0] key_q, key_d;
	dqs_pkg::rsp_t      rsp_q, rsp_d;
	logic               done_q, done_d;

	dqs_pkg::cell_op_t  cell_op;
	logic signed [31:0] cell_data [QUEUE_DEPTH];
	logic signed [31:0] load_data;

	logic accept;
	logic full;
	logic empty;
	logic last_step;
	logic hit_now;
	logic push_full;

	assign accept    = start && (state_q == dqs_pkg::ST_IDLE);
	assign full      = (count_q == CW'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign last_step = (CW'(step_q) == (count_q - CW'(1)));
	assign hit_now   = search_q && !found_q && (cell_data[0] == key_q);
	assign load_data = (state_q == dqs_pkg::ST_SWEEP) ? cell_data[0] : request.item_value;
	assign push_full = accept && full && (request.func == dqs_pkg::FUNC_PUSH_FRONT ||
	                                      request.func == dqs_pkg::FUNC_PUSH_BACK);

	// cell row
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		dqs_pkg::cell_ctrl_t ctrl;
		logic signed [31:0]  prev_data;
		logic signed [31:0]  next_data;

		assign ctrl = '{op:       cell_op,
		                at_count: (count_q == CW'(i)),
		                at_last:  (count_q == CW'(i + 1))};

		if (i == 0) begin : g_head
			assign prev_data = request.item_value;
		end else begin : g_body
			assign prev_data = cell_data[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_data = cell_data[i];
		end else begin : g_inner
			assign next_data = cell_data[i+1];
		end

		dqs_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.prev_data (prev_data),
			.next_data (next_data),
			.load_data (load_data),
			.data      (cell_data[i])
		);
	end

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		step_d   = step_q;
		search_d = search_q;
		found_d  = found_q;
		pos_d    = pos_q;
		key_d    = key_q;
		rsp_d    = rsp_q;
		done_d   = 1'b0;
		cell_op  = dqs_pkg::CELL_HOLD;

		unique case (state_q)
			dqs_pkg::ST_IDLE: begin
				if (accept) begin
					rsp_d.status         = dqs_pkg::STAT_OK;
					rsp_d.popped_value   = '0;
					rsp_d.match_position = '0;
					done_d               = 1'b1;
					case (request.func)
						dqs_pkg::FUNC_PUSH_FRONT: begin
							if (full) begin
								rsp_d.status = dqs_pkg::STAT_FULL;
							end else begin
								cell_op = dqs_pkg::CELL_PUSH_FRONT;
								count_d = count_q + CW'(1);
							end
						end
						dqs_pkg::FUNC_PUSH_BACK: begin
							if (full) begin
								rsp_d.status = dqs_pkg::STAT_FULL;
							end else begin
								cell_op = dqs_pkg::CELL_PUSH_BACK;
								count_d = count_q + CW'(1);
							end
						end
						dqs_pkg::FUNC_POP_FRONT: begin
							if (empty) begin
								rsp_d.status = dqs_pkg::STAT_EMPTY;
							end else begin
								rsp_d.popped_value = cell_data[0];
								cell_op            = dqs_pkg::CELL_POP_FRONT;
								count_d            = count_q - CW'(1);
							end
						end
						dqs_pkg::FUNC_POP_BACK: begin
							if (empty) begin
								rsp_d.status = dqs_pkg::STAT_EMPTY;
							end else begin
								state_d  = dqs_pkg::ST_SWEEP;
								search_d = 1'b0;
								found_d  = 1'b0;
								step_d   = '0;
								done_d   = 1'b0;
							end
						end
						dqs_pkg::FUNC_SEARCH: begin
							if (empty) begin
								rsp_d.status = dqs_pkg::STAT_MISS;
							end else begin
								state_d  = dqs_pkg::ST_SWEEP;
								search_d = 1'b1;
								found_d  = 1'b0;
								pos_d    = '0;
								key_d    = request.item_value;
								step_d   = '0;
								done_d   = 1'b0;
							end
						end
						default: ;
					endcase
					rsp_d.entry_count = 5'(count_d);
				end
			end
			dqs_pkg::ST_SWEEP: begin
				cell_op = dqs_pkg::CELL_ROTATE;
				step_d  = step_q + IW'(1);
				if (hit_now) begin
					found_d = 1'b1;
					pos_d   = step_q;
				end
				if (last_step) begin
					state_d              = dqs_pkg::ST_IDLE;
					done_d               = 1'b1;
					rsp_d.status         = dqs_pkg::STAT_OK;
					rsp_d.popped_value   = '0;
					rsp_d.match_position = '0;
					if (search_q) begin
						if (found_q) begin
							rsp_d.match_position = 4'(pos_q);
						end else if (hit_now) begin
							rsp_d.match_position = 4'(step_q);
						end else begin
							rsp_d.status = dqs_pkg::STAT_MISS;
						end
					end else begin
						rsp_d.popped_value = cell_data[0];
						count_d            = count_q - CW'(1);
					end
					rsp_d.entry_count = 5'(count_d);
				end
			end
			default: state_d = dqs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dqs_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		step_q   <= step_d;
		search_q <= search_d;
		found_q  <= found_d;
		pos_q    <= pos_d;
		key_q    <= key_d;
		rsp_q    <= rsp_d;
	end

	assign busy   = (state_q != dqs_pkg::ST_IDLE);
	assign done   = done_q;
	assign result = rsp_q;

	`DQS_ASSERT_IMPLY(a_sweep_nonempty, clk, arst_n, state_q == dqs_pkg::ST_SWEEP, count_q != '0)
	`DQS_ASSERT_IMPLY(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH))
	`DQS_ASSERT_IMPLY(a_done_idle, clk, arst_n, done_q, state_q == dqs_pkg::ST_IDLE)
	`DQS_ASSERT_NEXT(a_full_push, clk, arst_n, push_full, done_q && rsp_q.status == dqs_pkg::STAT_FULL)

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// Deque with search: testbench
// Drives push, pop, search and unused operations through the start/busy port
// and checks every done strobe against a queue-based shadow of the deque.
// Directed corner cases first, then fill/drain/mixed random phases with
// random gaps between requests, except in a back-to-back stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	localparam int          DEPTH             = 16;
	localparam int          RANDOM_REQUESTS   = 530;
	localparam int          IDLE_PCT          = 23;
	localparam int          STALL_LIMIT       = 500;
	localparam int          DRAIN_CYCLES      = 24;
	localparam logic [2:0]  FUNC_UNUSED_FIRST = 3'd5;
	localparam int          FUNC_UNUSED_SPAN  = 2;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} mode_t;

	class deque_shadow;
		int depth;
		logic signed [31:0] held[$];
		dqs_pkg::rsp_t due_results[$];
		int mismatches;
		int checked;
		int pushes, pops, searches, search_hits, full_pushes, empty_pops, unused_ops;
		int fullest;

		function new(int d);
			depth = d;
		endfunction

		function void note_request(dqs_pkg::req_t r);
			dqs_pkg::rsp_t e;
			e = '0;
			case (r.func) inside
				dqs_pkg::FUNC_PUSH_FRONT, dqs_pkg::FUNC_PUSH_BACK: begin
					pushes++;
					if (held.size() >= depth) begin
						e.status = dqs_pkg::STAT_FULL;
						full_pushes++;
					end else if (r.func == dqs_pkg::FUNC_PUSH_FRONT) begin
						held.push_front(r.item_value);
					end else begin
						held.push_back(r.item_value);
					end
				end
				dqs_pkg::FUNC_POP_FRONT, dqs_pkg::FUNC_POP_BACK: begin
					pops++;
					if (held.size() == 0) begin
						e.status = dqs_pkg::STAT_EMPTY;
						empty_pops++;
					end else if (r.func == dqs_pkg::FUNC_POP_FRONT) begin
						e.popped_value = held.pop_front();
					end else begin
						e.popped_value = held.pop_back();
					end
				end
				dqs_pkg::FUNC_SEARCH: begin
					searches++;
					e.status = dqs_pkg::STAT_MISS;
					for (int i = 0; i < held.size(); i++) begin
						if (held[i] === r.item_value) begin
							e.status = dqs_pkg::STAT_OK;
							e.match_position = 4'(i);
							search_hits++;
							break;
						end
					end
				end
				default: unused_ops++;
			endcase
			e.entry_count = 5'(held.size());
			if (held.size() > fullest)
				fullest = held.size();
			due_results.push_back(e);
		endfunction

		function void check_result(dqs_pkg::rsp_t got);
			dqs_pkg::rsp_t e;
			checked++;
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] result with no request outstanding: %p", $realtime, got);
				return;
			end
			e = due_results.pop_front();
			if (got.status !== e.status || got.popped_value !== e.popped_value ||
			    got.match_position !== e.match_position ||
			    got.entry_count !== e.entry_count) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] mismatch exp st=%0d pop=%0d pos=%0d cnt=%0d / got st=%0d pop=%0d pos=%0d cnt=%0d",
					         $realtime, e.status, e.popped_value, e.match_position,
					         e.entry_count, got.status, got.popped_value,
					         got.match_position, got.entry_count);
			end
		endfunction
	endclass

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           start = 1'b0;
	dqs_pkg::req_t  request = '0;
	logic           busy;
	logic           done;
	dqs_pkg::rsp_t  result;

	deque_shadow shadow = new(DEPTH);
	bit    gaps_on = 1'b1;
	int    stall_cycles = 0;

	deque_with_search_top #(.QUEUE_DEPTH(DEPTH)) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done === 1'b1)
				shadow.check_result(result);
			if (start && busy === 1'b0)
				shadow.note_request(request);
		end
	end

	initial begin
		@(posedge arst_n);
		while (stall_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((start && busy === 1'b0) || done === 1'b1)
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
		$display("FAIL deque_with_search_top");
		$finish;
	end

	task automatic send_request(logic [2:0] f, logic signed [31:0] v);
		dqs_pkg::req_t r;
		r.func = f;
		r.item_value = v;
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy !== 1'b0);
		while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] pick_value(logic [2:0] f);
		int r;
		r = $urandom_range(99);
		if (f == dqs_pkg::FUNC_SEARCH && shadow.held.size() != 0 && r < 60)
			return shadow.held[$urandom_range(shadow.held.size() - 1)];
		r = $urandom_range(99);
		if (r < 45)
			return 32'($urandom_range(7)) - 32'sd3;
		else if (r < 55)
			return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
		return $urandom;
	endfunction

	function automatic logic [2:0] pick_func(mode_t mode);
		int r;
		int push_w;
		int pop_w;
		push_w = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 12 : 38;
		pop_w  = (mode == MODE_FILL) ? 12 : (mode == MODE_DRAIN) ? 65 : 38;
		r = $urandom_range(99);
		if (r < 3)
			return FUNC_UNUSED_FIRST + 3'($urandom_range(FUNC_UNUSED_SPAN));
		if (r < 3 + push_w)
			return $urandom_range(1) ? dqs_pkg::FUNC_PUSH_FRONT : dqs_pkg::FUNC_PUSH_BACK;
		if (r < 3 + push_w + pop_w)
			return $urandom_range(1) ? dqs_pkg::FUNC_POP_FRONT : dqs_pkg::FUNC_POP_BACK;
		return dqs_pkg::FUNC_SEARCH;
	endfunction

	initial begin
		logic [2:0] f;
		mode_t      mode;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty-queue corners, then extremes, last-entry search, duplicates
		send_request(dqs_pkg::FUNC_POP_FRONT, 32'sd0);
		send_request(dqs_pkg::FUNC_POP_BACK, 32'sh7fffffff);
		send_request(dqs_pkg::FUNC_SEARCH, 32'sd0);
		send_request(FUNC_UNUSED_FIRST, 32'sd1);
		send_request(dqs_pkg::FUNC_PUSH_BACK, 32'sh7fffffff);
		send_request(dqs_pkg::FUNC_PUSH_FRONT, 32'sh80000000);
		send_request(dqs_pkg::FUNC_PUSH_BACK, -32'sd1);
		send_request(dqs_pkg::FUNC_PUSH_FRONT, 32'sd0);
		send_request(dqs_pkg::FUNC_PUSH_BACK, 32'sh55555555);
		send_request(dqs_pkg::FUNC_PUSH_FRONT, 32'shaaaaaaaa);
		send_request(dqs_pkg::FUNC_SEARCH, 32'sh55555555);
		send_request(dqs_pkg::FUNC_SEARCH, 32'shaaaaaaaa);
		send_request(dqs_pkg::FUNC_SEARCH, 32'sh80000000);
		send_request(dqs_pkg::FUNC_SEARCH, 32'sd12345);
		send_request(dqs_pkg::FUNC_PUSH_BACK, 32'sd0);
		send_request(dqs_pkg::FUNC_SEARCH, 32'sd0);
		send_request(FUNC_UNUSED_FIRST + 3'd1, -32'sd1);
		send_request(FUNC_UNUSED_FIRST + 3'd2, 32'sh80000000);
		send_request(dqs_pkg::FUNC_POP_BACK, 32'sd0);
		send_request(dqs_pkg::FUNC_POP_FRONT, 32'sd0);
		send_request(dqs_pkg::FUNC_POP_BACK, 32'sd0);
		send_request(dqs_pkg::FUNC_POP_FRONT, 32'sd0);

		mode = MODE_FILL;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n % 40 == 0)
				mode = mode_t'((n / 40) % 3);
			gaps_on = !(n >= 250 && n < 350);
			f = pick_func(mode);
			send_request(f, pick_value(f));
		end
		start <= 1'b0;

		while (shadow.due_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d pushes (%0d when full), %0d pops (%0d when empty), %0d unused codes",
		         shadow.pushes, shadow.full_pushes, shadow.pops, shadow.empty_pops,
		         shadow.unused_ops);
		$display("%0d searches with %0d hits, peak fill %0d of %0d; %0d results, %0d mismatches",
		         shadow.searches, shadow.search_hits, shadow.fullest, DEPTH,
		         shadow.checked, shadow.mismatches);
		if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
			$display("PASS deque_with_search_top");
		else
			$display("FAIL deque_with_search_top");
		$finish;
	end

endmodule
